[sv/rau_pkg.sv]
// Shared types and codes of the rational arithmetic unit.
`default_nettype none
package rau_pkg;
   localparam int MAG_W = 64;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_CMP = 3'd4,
      OP_RED = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_OPD = 2'd1,
      ST_BAD_RES = 2'd2
   } status_type;

   localparam logic [1:0] CMP_LESS = 2'b11;
   localparam logic [1:0] CMP_EQ   = 2'b00;
   localparam logic [1:0] CMP_GT   = 2'b01;
endpackage
`default_nettype wire

[sv/rau_gcd_div.sv]
// Binary GCD engine with a shared restoring divider that reduces a fraction.
`default_nettype none
module rau_gcd_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [rau_pkg::MAG_W-1:0]  num_mag,
   input  wire logic [rau_pkg::MAG_W-1:0]  den_mag,
   output logic                            done,
   output logic [rau_pkg::MAG_W-1:0]       num_q,
   output logic [rau_pkg::MAG_W-1:0]       den_q
);
   import rau_pkg::*;

   typedef enum logic [4:0] {
      G_IDLE = 5'b00001,
      G_GCD  = 5'b00010,
      G_DIVN = 5'b00100,
      G_DIVD = 5'b01000,
      G_DONE = 5'b10000
   } gstate_type;

   gstate_type          state_ff, state_in;
   logic [MAG_W-1:0]    x_ff, x_in, y_ff, y_in, n_ff, n_in, d_ff, d_in;
   logic [MAG_W-1:0]    g_ff, g_in, q_ff, q_in, r_ff, r_in;
   logic [MAG_W-1:0]    nq_ff, nq_in, dq_ff, dq_in;
   logic [5:0]          k_ff, k_in, cnt_ff, cnt_in;
   logic [MAG_W:0]      rs;
   logic                ge;
   logic [MAG_W-1:0]    q_step, r_step;

   // One restoring division step: shift in the next dividend bit, try subtract.
   always_comb begin
      rs     = {r_ff, q_ff[MAG_W-1]};
      ge     = rs >= {1'b0, g_ff};
      r_step = ge ? MAG_W'(rs - {1'b0, g_ff}) : rs[MAG_W-1:0];
      q_step = {q_ff[MAG_W-2:0], ge};
   end

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; n_in = n_ff; d_in = d_ff;
      g_in = g_ff; q_in = q_ff; r_in = r_ff;
      nq_in = nq_ff; dq_in = dq_ff; k_in = k_ff; cnt_in = cnt_ff;
      case (state_ff)
         G_IDLE: begin
            if (start) begin
               x_in = num_mag; y_in = den_mag;
               n_in = num_mag; d_in = den_mag;
               k_in = '0;
               state_in = G_GCD;
            end
         end
         G_GCD: begin
            if (x_ff == '0 || y_ff == '0) begin
               g_in     = (x_ff == '0) ? (y_ff << k_ff) : (x_ff << k_ff);
               q_in     = n_ff;
               r_in     = '0;
               cnt_in   = '0;
               state_in = G_DIVN;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 6'd1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_in = x_ff - y_ff;
            end else begin
               y_in = y_ff - x_ff;
            end
         end
         G_DIVN: begin
            q_in   = q_step;
            r_in   = r_step;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == '1) begin
               nq_in    = q_step;
               q_in     = d_ff;
               r_in     = '0;
               state_in = G_DIVD;
            end
         end
         G_DIVD: begin
            q_in   = q_step;
            r_in   = r_step;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == '1) begin
               dq_in    = q_step;
               state_in = G_DONE;
            end
         end
         G_DONE: begin
            state_in = G_IDLE;
         end
         default: begin
            state_in = G_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      x_ff <= x_in; y_ff <= y_in; n_ff <= n_in; d_ff <= d_in;
      g_ff <= g_in; q_ff <= q_in; r_ff <= r_in;
      nq_ff <= nq_in; dq_ff <= dq_in; k_ff <= k_in;
   end

   assign done  = (state_ff == G_DONE);
   assign num_q = nq_ff;
   assign den_q = dq_ff;
endmodule
`default_nettype wire

[sv/rational_arithmetic_unit.sv]
// Rational arithmetic unit top level: operand intake, shared multiplier, reduction and result stage.
//
// Takes two signed fractions and an operation (add, subtract, multiply, divide,
// compare, reduce the first fraction) and returns one result per transfer, reduced
// to lowest terms with a positive denominator. The low OPERAND_WIDTH bits of each
// operand are used, sign extended. One 32x32 multiplier forms the three cross
// products in turn; a binary GCD engine on 64-bit magnitudes (one subtract or shift
// per cycle) and one restoring divider (run for numerator then denominator) finish
// the reduction. Compare skips the reduction, and an error status or unused
// operation code goes straight to the result stage. The input is ready only while
// the unit is idle; the result register lets the next item be taken while a
// finished result waits.
`default_nettype none
module rational_arithmetic_unit #(
   parameter int OPERAND_WIDTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,  // a_num, a_den, b_num, b_den (32 bits each)
   input  wire logic [2:0]   req_tuser,  // operation
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [135:0]      rsp_tdata,  // res_num[63:0], res_den[126:64], cmp_result[128:127], zero pad
   output logic [1:0]        rsp_tuser   // status
);
   import rau_pkg::*;

   localparam int SH = 32 - OPERAND_WIDTH;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_COMB = 5'b00100,
      S_RED  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   function automatic logic signed [31:0] take_opd(input logic [31:0] raw);
      logic [31:0] sh;
      sh = raw << SH;
      return $signed(sh) >>> SH;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : v;
   endfunction

   state_type            state_ff, state_in;
   logic [1:0]           step_ff, step_in;
   logic [2:0]           op_ff;
   logic [31:0]          man_ff, mad_ff, mbn_ff, mbd_ff;
   logic                 san_ff, sad_ff, sbn_ff, sbd_ff;
   logic [63:0]          p1_ff, p2_ff, p3_ff;
   logic                 nneg_ff, nneg_in, dneg_ff, dneg_in;
   logic [63:0]          fin_num_ff, fin_num_in;
   logic [62:0]          fin_den_ff, fin_den_in;
   logic [1:0]           fin_cmp_ff, fin_cmp_in;
   logic [1:0]           fin_st_ff, fin_st_in;
   logic                 rsp_valid_ff;
   logic [63:0]          res_num_ff;
   logic [62:0]          res_den_ff;
   logic [1:0]           res_cmp_ff, res_st_ff;

   logic signed [31:0]   an, ad, bn, bd;
   logic                 accept;
   logic [31:0]          mul_a, mul_b;
   logic [63:0]          mul_p;
   logic                 red_start;
   logic [63:0]          red_num, red_den;
   logic                 red_done;
   logic [63:0]          red_nq, red_dq;
   logic                 n1, n2;
   logic signed [64:0]   t1, t2;
   logic                 gt, lt;
   logic                 fneg;

   assign an = take_opd(req_tdata[31:0]);
   assign ad = take_opd(req_tdata[63:32]);
   assign bn = take_opd(req_tdata[95:64]);
   assign bd = take_opd(req_tdata[127:96]);

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Operand routing into the shared multiplier, one product per step.
   always_comb begin
      mul_a = man_ff;
      mul_b = mbd_ff;
      case (step_ff)
         2'd0: begin
            mul_a = man_ff;
            mul_b = (op_ff == OP_MUL) ? mbn_ff : ((op_ff == OP_RED) ? 32'd1 : mbd_ff);
         end
         2'd1: begin
            mul_a = mbn_ff;
            mul_b = mad_ff;
         end
         default: begin
            mul_a = mad_ff;
            mul_b = (op_ff == OP_DIV) ? mbn_ff : ((op_ff == OP_RED) ? 32'd1 : mbd_ff);
         end
      endcase
      mul_p = 64'(mul_a) * 64'(mul_b);
   end

   // Sign-and-magnitude combine of the cross products.
   always_comb begin
      n1 = (p1_ff != '0) && (san_ff ^ sbd_ff);
      n2 = (p2_ff != '0) && ((sbn_ff ^ sad_ff) ^ (op_ff == OP_SUB));
      t1 = n1 ? -$signed({1'b0, p1_ff}) : $signed({1'b0, p1_ff});
      t2 = ((p2_ff != '0) && (sbn_ff ^ sad_ff)) ? -$signed({1'b0, p2_ff})
                                                 : $signed({1'b0, p2_ff});
      gt = t1 > t2;
      lt = t1 < t2;
      fneg = (red_nq != '0) && (nneg_ff != dneg_ff);
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      nneg_in    = nneg_ff;
      dneg_in    = dneg_ff;
      fin_num_in = fin_num_ff;
      fin_den_in = fin_den_ff;
      fin_cmp_in = fin_cmp_ff;
      fin_st_in  = fin_st_ff;
      red_start  = 1'b0;
      red_num    = p1_ff;
      red_den    = p3_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               fin_num_in = '0;
               fin_den_in = '0;
               fin_cmp_in = CMP_EQ;
               fin_st_in  = ST_OK;
               step_in    = '0;
               if (req_tuser > OP_RED) begin
                  state_in = S_DONE;
               end else if (ad == '0 || (req_tuser != OP_RED && bd == '0)) begin
                  fin_st_in = ST_BAD_OPD;
                  state_in  = S_DONE;
               end else if (req_tuser == OP_DIV && bn == '0) begin
                  fin_st_in = ST_BAD_RES;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) begin
               state_in = S_COMB;
            end
         end
         S_COMB: begin
            state_in = S_RED;
            case (op_ff)
               OP_ADD, OP_SUB: begin
                  dneg_in = sad_ff ^ sbd_ff;
                  if (n1 == n2) begin
                     nneg_in = n1;
                     red_num = p1_ff + p2_ff;
                  end else if (p1_ff >= p2_ff) begin
                     nneg_in = n1;
                     red_num = p1_ff - p2_ff;
                  end else begin
                     nneg_in = n2;
                     red_num = p2_ff - p1_ff;
                  end
                  red_start = 1'b1;
               end
               OP_MUL: begin
                  nneg_in   = san_ff ^ sbn_ff;
                  dneg_in   = sad_ff ^ sbd_ff;
                  red_start = 1'b1;
               end
               OP_DIV: begin
                  nneg_in   = san_ff ^ sbd_ff;
                  dneg_in   = sad_ff ^ sbn_ff;
                  red_start = 1'b1;
               end
               OP_CMP: begin
                  // Flip the outcome when the common denominator is negative.
                  if (gt != (sad_ff ^ sbd_ff) && (gt || lt)) begin
                     fin_cmp_in = CMP_GT;
                  end else if (gt || lt) begin
                     fin_cmp_in = CMP_LESS;
                  end else begin
                     fin_cmp_in = CMP_EQ;
                  end
                  state_in = S_DONE;
               end
               default: begin
                  nneg_in   = san_ff;
                  dneg_in   = sad_ff;
                  red_start = 1'b1;
               end
            endcase
         end
         S_RED: begin
            if (red_done) begin
               fin_num_in = fneg ? 64'(-red_nq) : red_nq;
               fin_den_in = red_dq[62:0];
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            // Hold until the result register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   rau_gcd_div u_gcd_div (
      .clock   (clock),
      .reset   (reset),
      .start   (red_start),
      .num_mag (red_num),
      .den_mag (red_den),
      .done    (red_done),
      .num_q   (red_nq),
      .den_q   (red_dq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         op_ff  <= req_tuser;
         man_ff <= mag32(an); san_ff <= an[31];
         mad_ff <= mag32(ad); sad_ff <= ad[31];
         mbn_ff <= mag32(bn); sbn_ff <= bn[31];
         mbd_ff <= mag32(bd); sbd_ff <= bd[31];
      end
      if (state_ff == S_MUL) begin
         case (step_ff)
            2'd0:    p1_ff <= mul_p;
            2'd1:    p2_ff <= mul_p;
            default: p3_ff <= mul_p;
         endcase
      end
      nneg_ff    <= nneg_in;
      dneg_ff    <= dneg_in;
      fin_num_ff <= fin_num_in;
      fin_den_ff <= fin_den_in;
      fin_cmp_ff <= fin_cmp_in;
      fin_st_ff  <= fin_st_in;
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_tready)) begin
         res_num_ff <= fin_num_ff;
         res_den_ff <= fin_den_ff;
         res_cmp_ff <= fin_cmp_ff;
         res_st_ff  <= fin_st_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, res_cmp_ff, res_den_ff, res_num_ff};
   assign rsp_tuser  = res_st_ff;
endmodule
`default_nettype wire

[sv/rau_checker.sv]
// Port-level checks of the rational arithmetic unit and their binding.
`default_nettype none
module rau_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [135:0] rsp_tdata,
   input wire logic [1:0]   rsp_tuser
);
   import rau_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("undefined status code");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == '0)
      else $error("error result carries data");

   a_frac_no_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[126:64] != '0 |-> rsp_tdata[128:127] == CMP_EQ)
      else $error("fraction result carries a compare outcome");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken on consecutive cycles");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
